FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTB_ASSERT_NOW(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTB_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: hw/rtl/dtb_pkg.sv
// Types, constants and helper functions for the decimal to binary converter.
package dtb_pkg;

  localparam int MAX_BYTES = 16;
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int LEN_W     = $clog2(MAX_BYTES + 1);
  localparam int NB_W      = 5;
  localparam int CMP_W     = (LEN_W > NB_W) ? LEN_W : NB_W;
  localparam int BYTE_W    = 8;
  localparam int CARRY_W   = 4;
  localparam int PROD_W    = 12;

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [NB_W-1:0]   NB_RESET  = 5'd16;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_SIZE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_PUSH,
    ST_FINISH,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_ERR
  } state_t;

  // Priority: size beats invalid beats overflow.
  function automatic logic [1:0] err_rank(status_t code);
    logic [1:0] r;
    case (code)
      STAT_SIZE:     r = 2'd3;
      STAT_INVALID:  r = 2'd2;
      STAT_OVERFLOW: r = 2'd1;
      default:       r = 2'd0;
    endcase
    return r;
  endfunction

  // Sticky error update: only a stronger error replaces the current one.
  function automatic status_t err_merge(status_t cur, status_t raised);
    return (err_rank(raised) > err_rank(cur)) ? raised : cur;
  endfunction

endpackage

FILE: hw/rtl/decimal_to_binary_converter_core.sv
// Decimal string to little-endian binary converter, memory based.
//
// Input channel (in_valid/in_ready): one ASCII character per item with
// char_present, first_char and last_char flags. first_char clears the value
// before the character is taken; last_char emits the result after it.
// Output channel (out_valid/out_ready): one item per value byte, lowest
// byte first, last_byte on the final one; or a single error item.
// Config: cfg_we/cfg_wdata write number_bytes; the user must do so only while the block is idle (unenforced).
//
// For a digit, the value memory (one write port, one registered read port) is
// walked one byte per cycle for the multiply-by-ten-and-add pass, then a push
// step appends a non-zero carry as a new byte while room is left. Other characters
// pass from the check state straight to the finish state. On a last character
// each value byte is read from memory, then loaded into the output register.
// in_ready is high only while idle; the output register lets the next item
// be accepted while the final result still waits.
// A stalled receiver holds the output register and pauses the byte walk.
// Reset: value reads as zero, used length one, no error, number_bytes 16.
module decimal_to_binary_converter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dtb_pkg::BYTE_W-1:0]   char_code,
  input  logic                         char_present,
  input  logic                         first_char,
  input  logic                         last_char,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dtb_pkg::BYTE_W-1:0]   value_byte,
  output logic [1:0]                   status,
  output logic                         last_byte,
  input  logic                         cfg_we,
  input  logic [dtb_pkg::NB_W-1:0]     cfg_wdata
);

  // Value memory and per-entry valid bits (unwritten entries read as zero)
  logic [dtb_pkg::BYTE_W-1:0]    mem [dtb_pkg::MAX_BYTES];
  logic [dtb_pkg::MAX_BYTES-1:0] vld;
  logic [dtb_pkg::BYTE_W-1:0]    rd_data;
  logic                          rd_vld;

  dtb_pkg::state_t state, state_next;

  // Control and datapath registers
  logic [dtb_pkg::BYTE_W-1:0]  ch;
  logic                        pres;
  logic                        lst;
  logic [dtb_pkg::IDX_W-1:0]   idx;
  logic [dtb_pkg::CARRY_W-1:0] carry;
  logic [dtb_pkg::LEN_W-1:0]   len;
  dtb_pkg::status_t            err;
  dtb_pkg::status_t            emit_status;
  logic [dtb_pkg::NB_W-1:0]    nb;
  logic [dtb_pkg::BYTE_W-1:0]  out_byte;
  dtb_pkg::status_t            out_status;
  logic                        out_last;

  // Memory port controls
  logic                        mem_rd_en;
  logic [dtb_pkg::IDX_W-1:0]   mem_rd_addr;
  logic                        mem_we;
  logic [dtb_pkg::IDX_W-1:0]   mem_wr_addr;
  logic [dtb_pkg::BYTE_W-1:0]  mem_wr_data;

  // Derived conditions
  logic                        in_acc;
  logic                        slot_free;
  logic                        size_ok;
  logic                        is_digit;
  logic                        room;
  logic                        len_over;
  logic                        more_bytes;
  logic                        last_out;
  logic [dtb_pkg::BYTE_W-1:0]  rd_byte;
  logic [dtb_pkg::PROD_W-1:0]  prod;

  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign size_ok   = (nb != '0) && (nb[1:0] == 2'b00) &&
                     (dtb_pkg::CMP_W'(nb) <= dtb_pkg::CMP_W'(dtb_pkg::MAX_BYTES));
  assign is_digit  = (ch >= dtb_pkg::CHAR_ZERO) && (ch <= dtb_pkg::CHAR_NINE);
  assign room      = (dtb_pkg::CMP_W'(len) < dtb_pkg::CMP_W'(nb)) &&
                     (dtb_pkg::CMP_W'(len) < dtb_pkg::CMP_W'(dtb_pkg::MAX_BYTES));
  assign len_over  = dtb_pkg::CMP_W'(len) > dtb_pkg::CMP_W'(nb);
  assign more_bytes = (dtb_pkg::LEN_W'(idx) + dtb_pkg::LEN_W'(1)) < len;
  assign last_out  = (dtb_pkg::CMP_W'(idx) + dtb_pkg::CMP_W'(1)) == dtb_pkg::CMP_W'(nb);

  // Byte times ten plus carry: shift-and-add
  assign rd_byte = rd_vld ? rd_data : '0;
  assign prod    = {1'b0, rd_byte, 3'b000} + {3'b000, rd_byte, 1'b0} +
                   dtb_pkg::PROD_W'(carry);

  assign in_ready   = (state == dtb_pkg::ST_IDLE);
  assign value_byte = out_byte;
  assign status     = out_status;
  assign last_byte  = out_last;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dtb_pkg::ST_IDLE: begin
        if (in_valid) state_next = dtb_pkg::ST_CHECK;
      end
      dtb_pkg::ST_CHECK: begin
        if (pres && size_ok && is_digit && err == dtb_pkg::STAT_OK) begin
          state_next = dtb_pkg::ST_MUL;
        end else begin
          state_next = dtb_pkg::ST_FINISH;
        end
      end
      dtb_pkg::ST_MUL: begin
        if (!more_bytes) state_next = dtb_pkg::ST_PUSH;
      end
      dtb_pkg::ST_PUSH: begin
        state_next = dtb_pkg::ST_FINISH;
      end
      dtb_pkg::ST_FINISH: begin
        if (!lst) begin
          state_next = dtb_pkg::ST_IDLE;
        end else if (!size_ok || len_over || err != dtb_pkg::STAT_OK) begin
          state_next = dtb_pkg::ST_EMIT_ERR;
        end else begin
          state_next = dtb_pkg::ST_EMIT_RD;
        end
      end
      dtb_pkg::ST_EMIT_RD: begin
        state_next = dtb_pkg::ST_EMIT_LD;
      end
      dtb_pkg::ST_EMIT_LD: begin
        if (slot_free) begin
          state_next = last_out ? dtb_pkg::ST_IDLE : dtb_pkg::ST_EMIT_RD;
        end
      end
      dtb_pkg::ST_EMIT_ERR: begin
        if (slot_free) state_next = dtb_pkg::ST_IDLE;
      end
      default: state_next = dtb_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx;
    mem_we      = 1'b0;
    mem_wr_addr = idx;
    mem_wr_data = prod[dtb_pkg::BYTE_W-1:0];
    case (state)
      dtb_pkg::ST_CHECK: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
      end
      dtb_pkg::ST_MUL: begin
        mem_we      = 1'b1;
        mem_rd_en   = more_bytes;
        mem_rd_addr = idx + dtb_pkg::IDX_W'(1);
      end
      dtb_pkg::ST_PUSH: begin
        mem_we      = (carry != '0) && room;
        mem_wr_addr = len[dtb_pkg::IDX_W-1:0];
        mem_wr_data = dtb_pkg::BYTE_W'(carry);
      end
      dtb_pkg::ST_EMIT_RD: begin
        mem_rd_en = 1'b1;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wr_addr] <= mem_wr_data;
    if (mem_rd_en) begin
      rd_data <= mem[mem_rd_addr];
      rd_vld  <= vld[mem_rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtb_pkg::ST_IDLE;
      vld   <= '0;
      len   <= dtb_pkg::LEN_W'(1);
      err   <= dtb_pkg::STAT_OK;
      nb    <= dtb_pkg::NB_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) nb <= cfg_wdata;
      if (mem_we) vld[mem_wr_addr] <= 1'b1;
      case (state)
        dtb_pkg::ST_IDLE: begin
          if (in_acc && first_char) begin
            vld <= '0;
            len <= dtb_pkg::LEN_W'(1);
            err <= dtb_pkg::STAT_OK;
          end
        end
        dtb_pkg::ST_CHECK: begin
          if (pres && !size_ok) begin
            err <= dtb_pkg::err_merge(err, dtb_pkg::STAT_SIZE);
          end else if (pres && !is_digit) begin
            err <= dtb_pkg::err_merge(err, dtb_pkg::STAT_INVALID);
          end
        end
        dtb_pkg::ST_PUSH: begin
          if (carry != '0) begin
            if (room) begin
              len <= len + dtb_pkg::LEN_W'(1);
            end else begin
              err <= dtb_pkg::err_merge(err, dtb_pkg::STAT_OVERFLOW);
            end
          end
        end
        dtb_pkg::ST_FINISH: begin
          if (lst && size_ok && len_over) begin
            err <= dtb_pkg::err_merge(err, dtb_pkg::STAT_OVERFLOW);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch   <= char_code;
      pres <= char_present;
      lst  <= last_char;
    end
    case (state)
      dtb_pkg::ST_CHECK: begin
        idx   <= '0;
        carry <= dtb_pkg::CARRY_W'(ch - dtb_pkg::CHAR_ZERO);
      end
      dtb_pkg::ST_MUL: begin
        carry <= prod[dtb_pkg::PROD_W-1:dtb_pkg::BYTE_W];
        if (more_bytes) idx <= idx + dtb_pkg::IDX_W'(1);
      end
      dtb_pkg::ST_FINISH: begin
        idx <= '0;
        if (!size_ok) begin
          emit_status <= dtb_pkg::STAT_SIZE;
        end else if (len_over) begin
          emit_status <= dtb_pkg::err_merge(err, dtb_pkg::STAT_OVERFLOW);
        end else begin
          emit_status <= err;
        end
      end
      dtb_pkg::ST_EMIT_LD: begin
        if (slot_free) idx <= idx + dtb_pkg::IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dtb_pkg::ST_EMIT_LD && slot_free) begin
      out_valid <= 1'b1;
    end else if (state == dtb_pkg::ST_EMIT_ERR && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dtb_pkg::ST_EMIT_LD && slot_free) begin
      out_byte   <= rd_byte;
      out_status <= dtb_pkg::STAT_OK;
      out_last   <= last_out;
    end else if (state == dtb_pkg::ST_EMIT_ERR && slot_free) begin
      out_byte   <= '0;
      out_status <= emit_status;
      out_last   <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/dtb_checker.sv
// Port-level checker for the decimal to binary converter, with its bind.
`include "assert_macros.svh"

module dtb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dtb_pkg::BYTE_W-1:0] value_byte,
  input logic [1:0]                 status,
  input logic                       last_byte
);

  // A stalled result holds its payload
  `DTB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(value_byte) && $stable(status) && $stable(last_byte), "stalled result changed")

  // An error result is a lone zero byte that ends the run
  `DTB_ASSERT_NOW(a_err_item, clk, rst, out_valid && status != dtb_pkg::STAT_OK, value_byte == '0 && last_byte, "error result malformed")

  // One character at a time: ready drops after each accepted item
  `DTB_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "item accepted while busy")

endmodule

bind decimal_to_binary_converter_core dtb_checker u_dtb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value_byte (value_byte),
  .status     (status),
  .last_byte  (last_byte)
);

FILE: dv/decimal_to_binary_converter_core_test.sv
// Testbench for the decimal to binary converter core: random and directed strings.
`timescale 1ns / 100ps

module decimal_to_binary_converter_core_test;

  // One input character with its framing flags
  typedef struct {
    logic [7:0] code;
    logic       present;
    logic       is_first;
    logic       is_last;
  } char_item_t;

  // One output byte as the block should deliver it
  typedef struct {
    logic [7:0]       byte_val;
    dtb_pkg::status_t stat;
    logic             is_final;
  } out_byte_t;

  localparam int SETTLE_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       char_present = 1'b0;
  logic       first_char = 1'b0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] value_byte;
  logic [1:0] status;
  logic       last_byte;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = 5'd0;

  // Pending input items and expected output bytes
  char_item_t char_queue [$];
  out_byte_t  expected_bytes [$];
  char_item_t cur_item;
  int         error_count = 0;
  int         bytes_seen = 0;

  // Predicted converter state
  logic [7:0]       acc_mem [dtb_pkg::MAX_BYTES];
  int unsigned      acc_len = 1;
  dtb_pkg::status_t acc_err = dtb_pkg::STAT_OK;
  logic [4:0]       width_cfg = dtb_pkg::NB_RESET;

  // Sender burst/gap and receiver stall bookkeeping
  int burst_left = 0;
  int gap_left = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  decimal_to_binary_converter_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .char_present (char_present),
    .first_char   (first_char),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_byte   (value_byte),
    .status       (status),
    .last_byte    (last_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int severity(dtb_pkg::status_t c);
    case (c)
      dtb_pkg::STAT_SIZE:     return 3;
      dtb_pkg::STAT_INVALID:  return 2;
      dtb_pkg::STAT_OVERFLOW: return 1;
      default:                return 0;
    endcase
  endfunction

  // Sticky error: a weaker code never replaces a stronger one
  task automatic flag_error(dtb_pkg::status_t c);
    if (severity(c) > severity(acc_err)) acc_err = c;
  endtask

  function automatic bit width_legal();
    return width_cfg != 0 && width_cfg % 4 == 0 && width_cfg <= dtb_pkg::MAX_BYTES;
  endfunction

  // Grow the value by one byte, or flag overflow when out of room
  task automatic append_carry(int unsigned carry);
    if (carry == 0) return;
    if (acc_len < width_cfg && acc_len < dtb_pkg::MAX_BYTES) begin
      acc_mem[acc_len] = 8'(carry);
      acc_len++;
    end else begin
      flag_error(dtb_pkg::STAT_OVERFLOW);
    end
  endtask

  // value = value * 10 + digit
  task automatic mul_add(int unsigned digit);
    int unsigned n;
    int unsigned p;
    int unsigned carry;
    int unsigned i;
    n = (acc_len > dtb_pkg::MAX_BYTES) ? dtb_pkg::MAX_BYTES : acc_len;
    carry = 0;
    for (i = 0; i < n; i++) begin
      p = acc_mem[i] * 10 + carry;
      acc_mem[i] = 8'(p);
      carry = p >> 8;
    end
    append_carry(carry);
    if (acc_err != dtb_pkg::STAT_OK) return;
    n = (acc_len > dtb_pkg::MAX_BYTES) ? dtb_pkg::MAX_BYTES : acc_len;
    carry = digit;
    for (i = 0; i < n && carry != 0; i++) begin
      p = acc_mem[i] + carry;
      acc_mem[i] = 8'(p);
      carry = p >> 8;
    end
    append_carry(carry);
  endtask

  // Apply one accepted character and queue the bytes it produces
  task automatic convert_step(char_item_t it);
    dtb_pkg::status_t st;
    out_byte_t        ob;
    int               k;
    if (it.is_first) begin
      for (k = 0; k < dtb_pkg::MAX_BYTES; k++) acc_mem[k] = 8'h00;
      acc_len = 1;
      acc_err = dtb_pkg::STAT_OK;
    end
    if (it.present) begin
      if (!width_legal()) begin
        flag_error(dtb_pkg::STAT_SIZE);
      end else if (it.code < dtb_pkg::CHAR_ZERO || it.code > dtb_pkg::CHAR_NINE) begin
        flag_error(dtb_pkg::STAT_INVALID);
      end else if (acc_err == dtb_pkg::STAT_OK) begin
        mul_add(32'(it.code - dtb_pkg::CHAR_ZERO));
      end
    end
    if (!it.is_last) return;
    st = acc_err;
    if (!width_legal()) begin
      st = dtb_pkg::STAT_SIZE;
    end else if (acc_len > width_cfg) begin
      flag_error(dtb_pkg::STAT_OVERFLOW);
      st = acc_err;
    end
    if (st != dtb_pkg::STAT_OK) begin
      ob.byte_val = 8'h00;
      ob.stat = st;
      ob.is_final = 1'b1;
      expected_bytes.push_back(ob);
    end else begin
      for (k = 0; k < width_cfg; k++) begin
        ob.byte_val = acc_mem[k];
        ob.stat = dtb_pkg::STAT_OK;
        ob.is_final = (k + 1 == width_cfg);
        expected_bytes.push_back(ob);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) convert_step(cur_item);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (char_queue.size() > 0) begin
        cur_item = char_queue.pop_front();
        char_code <= cur_item.code;
        char_present <= cur_item.present;
        first_char <= cur_item.is_first;
        last_char <= cur_item.is_last;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    out_byte_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      // Compare each delivered byte with the oldest expectation
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected output item: value_byte %0h status %0d", value_byte, status);
          error_count++;
        end else begin
          e = expected_bytes.pop_front();
          if (value_byte !== e.byte_val) begin
            $error("value_byte: expected %0h, got %0h", e.byte_val, value_byte);
            error_count++;
          end
          if (status !== e.stat) begin
            $error("status: expected %0d, got %0d", e.stat, status);
            error_count++;
          end
          if (last_byte !== e.is_final) begin
            $error("last_byte: expected %0b, got %0b", e.is_final, last_byte);
            error_count++;
          end
        end
      end

      // Ready pattern: one long hold-off while input is still queued, else random modes
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && bytes_seen >= 40 && char_queue.size() > 20) begin
        held_once = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(logic [7:0] code, logic present, logic is_first, logic is_last);
    char_item_t it;
    it.code = code;
    it.present = present;
    it.is_first = is_first;
    it.is_last = is_last;
    char_queue.push_back(it);
  endtask

  task automatic queue_digits(string s, bit is_first, bit is_last);
    int i;
    for (i = 0; i < s.len(); i++)
      add_item(s[i], 1'b1, is_first && i == 0, is_last && i == s.len() - 1);
  endtask

  // Wait until every item is sent and every byte is back, then let the core go idle
  task automatic drain_and_settle();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_cfg = v;
  endtask

  // Mostly well-formed numbers with random digits, plus broken strings and noise
  task automatic random_phase(int budget);
    int         added;
    int         roll;
    int         len;
    int         maxdig;
    int         bad_at;
    int         i;
    logic [7:0] c;
    maxdig = (width_legal() ? int'(width_cfg) : 4) * 12 / 5 + 2;
    added = 0;
    while (added < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(maxdig - 3, maxdig)
                                          : $urandom_range(1, maxdig - 3);
        bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
        for (i = 0; i < len; i++) begin
          if (i == bad_at) begin
            do c = 8'($urandom_range(0, 255));
            while (c >= dtb_pkg::CHAR_ZERO && c <= dtb_pkg::CHAR_NINE);
          end else begin
            c = dtb_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
          end
          add_item(c, 1'b1, i == 0, i == len - 1);
        end
        added += len;
      end else if (roll < 88) begin
        // continue the stored value without a first char, or start one without ending it
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++)
          add_item(dtb_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1,
                   roll >= 82 && i == 0, roll < 82 && i == len - 1);
        added += len;
      end else begin
        add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  initial begin
    int unsigned plan [11];
    int unsigned w;
    int          i;
    for (i = 0; i < dtb_pkg::MAX_BYTES; i++) acc_mem[i] = 8'h00;
    plan = '{8, 12, 31, 16, 4, 0, 16, 8, 12, 4, 16};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Four bytes: all-ones value, then one more digit overflows without a first char
    write_width(5'd4);
    queue_digits("4294967295", 1'b1, 1'b1);
    queue_digits("0", 1'b0, 1'b1);
    // Empty string gives an all-zero value
    add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
    // Decimal point and extreme codes are invalid
    add_item(8'h2e, 1'b1, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0, 1'b1);
    drain_and_settle();

    // Zero size is a bad size, with and without a character
    write_width(5'd0);
    queue_digits("5", 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1, 1'b1);
    drain_and_settle();

    // Five-byte value built at 16 bytes, then read out after shrinking to 4
    write_width(5'd16);
    queue_digits("9999999999", 1'b1, 1'b0);
    drain_and_settle();
    write_width(5'd4);
    add_item(8'h00, 1'b0, 1'b0, 1'b1);
    drain_and_settle();

    // Random phases over legal and illegal sizes
    for (i = 0; i < 11; i++) begin
      w = plan[i];
      if (w == 0) begin
        do w = $urandom_range(1, 30);
        while (w % 4 == 0 && w <= dtb_pkg::MAX_BYTES);
      end
      write_width(5'(w));
      random_phase(width_legal() ? 36 : 12);
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dtb_pkg.sv
hw/rtl/decimal_to_binary_converter_core.sv
hw/rtl/dtb_checker.sv
dv/decimal_to_binary_converter_core_test.sv
